/* src/mmcs_pkg.sv */
// ============================================================================
// mmcs_pkg
// Shared types and constants of the min-max contrast stretch block.
// ============================================================================
package mmcs_pkg;

  // Pixel width (Q12.4 in, Q8.8 out).
  localparam int PIX_W = 16;

  // Configuration port.
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 1;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  // Reset value of both frame size registers.
  localparam logic [CFG_W-1:0] DIM_RESET = 9'd256;

  // Item opcodes.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  // 255.0 in Q12.4 (reset of the running minimum) and in Q8.8 (full scale).
  localparam logic [PIX_W-1:0] MIN_RESET  = 16'd4080;
  localparam logic [PIX_W-1:0] FULL_SCALE = 16'd65280;

  // Job queue between the front and the back.
  localparam int QDEPTH = 2;
  localparam int QAW    = 1;
  localparam int QLVL_W = 2;

  // Radix-2 divider: one quotient bit per step.
  localparam int DIV_STEPS = 16;
  localparam int CNT_W     = 4;

  // One stretch job: stored pixel plus the extremes of its frame.
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [PIX_W-1:0] lo;
    logic [PIX_W-1:0] hi;
    logic             last;
  } stretch_job_t;

  // Queue write side, driven by the front.
  typedef struct packed {
    logic         valid;
    stretch_job_t job;
  } job_push_t;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_PREP,
    BK_DIV,
    BK_DONE
  } back_state_e;

endpackage

/* src/min_max_contrast_stretch.sv */
// ============================================================================
// min_max_contrast_stretch
// Min-max contrast stretch of one frame held in an on-chip store.
// ============================================================================
// Usage:
//   Items enter through push/full. A load item (opcode 0) writes pixel_in_i
//   to the frame store and updates the running extremes; it gives no
//   result. Once width times height pixels are loaded, each fetch item
//   (opcode 1) yields one stretched Q8.8 pixel on the result side, with
//   last_of_frame_o set on the final pixel of the frame.
//   Fetches during loading and loads during read-out are dropped.
//   Results leave through empty/pop; the oldest result sits on the ports
//   while empty is low.
//   A fetch passes through a store read, the queue, a dequeue by the back
//   end, a prepare step, 16 divider steps and a writeback into the result
//   register; a flat frame or a pixel at either extreme skips the divider.
//   The back end works on one pixel at a time, so further fetch jobs wait
//   in the queue while the radix-2 divider is busy.
//   Loads go at one per cycle while full is low.
//   Reset clears counters, resets the extremes and sets both frame size
//   registers to 256; the store is not cleared. If the receiver stalls, the
//   result register holds, the divider finishes one more pixel, the
//   two-entry queue fills and full rises.
// ============================================================================
module min_max_contrast_stretch #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mmcs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [mmcs_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                           push,
  output logic                           full,
  input  logic                           opcode_i,
  input  logic [mmcs_pkg::PIX_W-1:0]     pixel_in_i,
  output logic                           empty,
  input  logic                           pop,
  output logic [mmcs_pkg::PIX_W-1:0]     scaled_pixel_o,
  output logic                           last_of_frame_o
);
  import mmcs_pkg::*;

  job_push_t        job_push;
  stretch_job_t     q_head;
  logic             q_nonempty;
  logic             q_pop;
  logic [QLVL_W-1:0] q_level;
  logic             pend;
  logic             accept;
  logic [QLVL_W:0]  in_flight;

  // Hold off new items while the queue has no room for another job.
  assign in_flight = {1'b0, q_level} + (QLVL_W + 1)'(pend);
  assign full      = (in_flight >= (QLVL_W + 1)'(QDEPTH));
  assign accept    = push && !full;

  mmcs_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .opcode_i   (opcode_i),
    .pixel_in_i (pixel_in_i),
    .pend_o     (pend),
    .push_o     (job_push)
  );

  mmcs_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (job_push),
    .pop_en_i   (q_pop),
    .head_o     (q_head),
    .nonempty_o (q_nonempty),
    .level_o    (q_level)
  );

  mmcs_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (q_head),
    .nonempty_i      (q_nonempty),
    .q_pop_o         (q_pop),
    .pop             (pop),
    .empty           (empty),
    .scaled_pixel_o  (scaled_pixel_o),
    .last_of_frame_o (last_of_frame_o)
  );

endmodule

/* src/mmcs_queue.sv */
// ============================================================================
// mmcs_queue
// Short job queue that decouples the front from the divider back end.
// ============================================================================
module mmcs_queue (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mmcs_pkg::job_push_t        push_i,
  input  logic                       pop_en_i,
  output mmcs_pkg::stretch_job_t     head_o,
  output logic                       nonempty_o,
  output logic [mmcs_pkg::QLVL_W-1:0] level_o
);
  import mmcs_pkg::*;

  stretch_job_t         slot_q [QDEPTH];
  logic [QAW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [QAW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [QLVL_W-1:0]    level_q, level_d;
  logic                 do_pop;

  assign do_pop     = pop_en_i && (level_q != '0);
  assign head_o     = slot_q[rd_ptr_q];
  assign nonempty_o = (level_q != '0);
  assign level_o    = level_q;

  // Pointer and fill level update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    level_d  = level_q;
    if (push_i.valid) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    case ({push_i.valid, do_pop})
      2'b10:   level_d = level_q + 1'b1;
      2'b01:   level_d = level_q - 1'b1;
      default: level_d = level_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      slot_q[wr_ptr_q] <= push_i.job;
    end
  end

endmodule

/* src/mmcs_front.sv */
// ============================================================================
// mmcs_front
// Accepts items, loads the frame store, tracks the extremes and issues one
// stretch job per fetch during read-out.
// ============================================================================
module mmcs_front #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mmcs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [mmcs_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          accept_i,
  input  logic                          opcode_i,
  input  logic [mmcs_pkg::PIX_W-1:0]     pixel_in_i,
  output logic                          pend_o,
  output mmcs_pkg::job_push_t            push_o
);
  import mmcs_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);

  // Frame store, no reset.
  logic [PIX_W-1:0] store_mem [DEPTH];
  logic [PIX_W-1:0] rd_data_q;

  logic [CFG_W-1:0] width_q, height_q;
  logic [WW-1:0]    eff_w;
  logic [HW-1:0]    eff_h;
  logic [CW-1:0]    total;

  logic [CW-1:0]    load_cnt_q, load_cnt_d;
  logic [CW-1:0]    read_cnt_q, read_cnt_d;
  logic [CW-1:0]    load_next, read_next;
  logic             phase_q, phase_d;
  logic [PIX_W-1:0] min_q, min_d;
  logic [PIX_W-1:0] max_q, max_d;

  logic             pend_q, pend_d;
  logic [PIX_W-1:0] pend_lo_q, pend_hi_q;
  logic             pend_last_q, pend_last_d;

  logic             do_load, do_fetch, store_we;
  logic [AW-1:0]    store_addr;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_RESET;
      height_q <= DIM_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FRAME_WIDTH:  width_q  <= cfg_data_i;
        REG_FRAME_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp the frame size into 1..MAX and form the pixel count.
  always_comb begin
    if (width_q == '0) begin
      eff_w = WW'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(width_q);
    end
    if (height_q == '0) begin
      eff_h = HW'(1);
    end else if (32'(height_q) > MAX_HEIGHT) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = HW'(height_q);
    end
    total = CW'(eff_w) * CW'(eff_h);
  end

  // Item classification.
  assign do_load    = accept_i && (opcode_i == OP_LOAD) && !phase_q;
  assign do_fetch   = accept_i && (opcode_i == OP_FETCH) && phase_q;
  assign store_we   = do_load && (load_cnt_q < CW'(DEPTH));
  assign store_addr = do_load ? load_cnt_q[AW-1:0] : read_cnt_q[AW-1:0];
  assign load_next  = load_cnt_q + 1'b1;
  assign read_next  = read_cnt_q + 1'b1;

  // Frame state: counters, extremes and phase.
  always_comb begin
    load_cnt_d  = load_cnt_q;
    read_cnt_d  = read_cnt_q;
    phase_d     = phase_q;
    min_d       = min_q;
    max_d       = max_q;
    pend_d      = do_fetch;
    pend_last_d = (read_next >= total);
    if (do_load) begin
      load_cnt_d = load_next;
      if (pixel_in_i > max_q) begin
        max_d = pixel_in_i;
      end
      if (pixel_in_i < min_q) begin
        min_d = pixel_in_i;
      end
      if (load_next >= total) begin
        phase_d = 1'b1;
      end
    end
    if (do_fetch) begin
      if (pend_last_d) begin
        load_cnt_d = '0;
        read_cnt_d = '0;
        phase_d    = 1'b0;
        min_d      = MIN_RESET;
        max_d      = '0;
      end else begin
        read_cnt_d = read_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_cnt_q <= '0;
      read_cnt_q <= '0;
      phase_q    <= 1'b0;
      min_q      <= MIN_RESET;
      max_q      <= '0;
      pend_q     <= 1'b0;
    end else begin
      load_cnt_q <= load_cnt_d;
      read_cnt_q <= read_cnt_d;
      phase_q    <= phase_d;
      min_q      <= min_d;
      max_q      <= max_d;
      pend_q     <= pend_d;
    end
  end

  // Job fields that travel with the store read.
  always_ff @(posedge clk_i) begin
    if (do_fetch) begin
      pend_lo_q   <= min_q;
      pend_hi_q   <= max_q;
      pend_last_q <= pend_last_d;
    end
  end

  // Single-port frame store with registered read.
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_mem[store_addr] <= pixel_in_i;
    end
    if (do_fetch) begin
      rd_data_q <= store_mem[store_addr];
    end
  end

  // Job goes to the queue in the cycle after its fetch.
  assign pend_o           = pend_q;
  assign push_o.valid     = pend_q;
  assign push_o.job.pixel = rd_data_q;
  assign push_o.job.lo    = pend_lo_q;
  assign push_o.job.hi    = pend_hi_q;
  assign push_o.job.last  = pend_last_q;

endmodule

/* src/mmcs_back.sv */
// ============================================================================
// mmcs_back
// Stretches one queued pixel at a time with a radix-2 restoring divider and
// holds the result in an output register.
// ============================================================================
module mmcs_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mmcs_pkg::stretch_job_t         head_i,
  input  logic                          nonempty_i,
  output logic                          q_pop_o,
  input  logic                          pop,
  output logic                          empty,
  output logic [mmcs_pkg::PIX_W-1:0]     scaled_pixel_o,
  output logic                          last_of_frame_o
);
  import mmcs_pkg::*;

  back_state_e      state_q, state_d;
  stretch_job_t     job_q;
  logic [PIX_W-1:0] rem_q, rem_d;
  logic [PIX_W-1:0] quo_q, quo_d;
  logic [PIX_W-1:0] span_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             res_valid_q, res_valid_d;
  logic [PIX_W-1:0] res_pixel_q;
  logic             res_last_q;

  logic             special;
  logic [PIX_W-1:0] special_val;
  logic [PIX_W-1:0] diff;
  logic [2*PIX_W-1:0] num;
  logic [PIX_W:0]   rem_sh;
  logic             ge;
  logic             res_load;
  logic             div_done;

  // Edge cases: flat frame, pixel at or below min, pixel at or above max.
  always_comb begin
    special     = 1'b0;
    special_val = '0;
    if ((job_q.hi <= job_q.lo) || (job_q.pixel <= job_q.lo)) begin
      special = 1'b1;
    end else if (job_q.pixel >= job_q.hi) begin
      special     = 1'b1;
      special_val = FULL_SCALE;
    end
    diff = job_q.pixel - job_q.lo;
    // diff * 65280 = diff * 2^16 - diff * 2^8
    num  = {diff, {PIX_W{1'b0}}} - {8'd0, diff, 8'd0};
  end

  // One restoring division step.
  always_comb begin
    rem_sh = {rem_q, quo_q[PIX_W-1]};
    ge     = (rem_sh >= {1'b0, span_q});
  end

  assign div_done = (cnt_q == CNT_W'(DIV_STEPS - 1));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: if (nonempty_i) state_d = BK_PREP;
      BK_PREP: state_d = special ? BK_DONE : BK_DIV;
      BK_DIV:  if (div_done) state_d = BK_DONE;
      BK_DONE: if (!res_valid_q || pop) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    q_pop_o  = 1'b0;
    res_load = 1'b0;
    case (state_q)
      BK_IDLE: q_pop_o  = nonempty_i;
      BK_DONE: res_load = !res_valid_q || pop;
      default: ;
    endcase
  end

  // Datapath next values.
  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    case (state_q)
      BK_PREP: begin
        cnt_d = '0;
        if (special) begin
          quo_d = special_val;
        end else begin
          rem_d = num[2*PIX_W-1:PIX_W];
          quo_d = num[PIX_W-1:0];
        end
      end
      BK_DIV: begin
        cnt_d = cnt_q + 1'b1;
        rem_d = ge ? PIX_W'(rem_sh - {1'b0, span_q}) : rem_sh[PIX_W-1:0];
        quo_d = {quo_q[PIX_W-2:0], ge};
      end
      default: ;
    endcase
  end

  // Output register valid flag.
  always_comb begin
    res_valid_d = res_valid_q;
    if (res_load) begin
      res_valid_d = 1'b1;
    end else if (pop) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (q_pop_o) begin
      job_q <= head_i;
    end
    if (state_q == BK_PREP) begin
      span_q <= job_q.hi - job_q.lo;
    end
    if (res_load) begin
      res_pixel_q <= quo_q;
      res_last_q  <= job_q.last;
    end
  end

  assign empty           = !res_valid_q;
  assign scaled_pixel_o  = res_pixel_q;
  assign last_of_frame_o = res_last_q;

endmodule
